FILE: rtl/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared constants, result types and the month table for the Julian date
// to calendar converter.
// ----------------------------------------------------------------------------
package jdc_pkg;

  localparam int unsigned DAY_BITS_DEF  = 22;
  localparam int unsigned FRAC_BITS_DEF = 32;

  localparam int unsigned EPOCH_DAY    = 1721425;
  localparam int unsigned MIN_DAY      = 1721119;
  localparam int unsigned DAYS_400Y    = 146097;
  localparam int unsigned DAYS_100Y    = 36524;
  localparam int unsigned DAYS_4Y      = 1461;
  localparam int unsigned DAYS_1Y      = 365;
  localparam int unsigned DAYS_JAN_FEB = 59;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned MONTH_MUL    = 12;
  localparam int unsigned MONTH_BIAS   = 373;
  localparam int unsigned MONTH_DIV    = 367;
  localparam int unsigned YEAR_SPAN    = 400;
  localparam int unsigned CENT_SPAN    = 100;

  // day number offset so that the 400-year quotient is never negative
  localparam int unsigned DEP_OFS = EPOCH_DAY - DAYS_400Y;

  // reciprocal multipliers: floor(n / d) = (n * M) >> K over the used range
  localparam int unsigned K1461 = 27;
  localparam int unsigned M1461 = ((1 << K1461) + DAYS_4Y - 1) / DAYS_4Y;
  localparam int unsigned K367  = 22;
  localparam int unsigned M367  = ((1 << K367) + MONTH_DIV - 1) / MONTH_DIV;
  localparam int unsigned K60   = 23;
  localparam int unsigned M60   = ((1 << K60) + SECS_PER_MIN - 1) / SECS_PER_MIN;

  localparam int unsigned R400_W  = 18;
  localparam int unsigned R100_W  = 16;
  localparam int unsigned R4_W    = 11;
  localparam int unsigned C100_W  = 3;
  localparam int unsigned Q4_W    = 5;
  localparam int unsigned YI_W    = 3;
  localparam int unsigned YDAY_W  = 9;
  localparam int unsigned MN_W    = 13;
  localparam int unsigned M1461_W = 17;
  localparam int unsigned M367_W  = 14;
  localparam int unsigned M60_W   = 18;
  localparam int unsigned SPD_W   = 17;
  localparam int unsigned TOD_W   = 17;
  localparam int unsigned Q60_W   = 11;

  localparam int unsigned YEAR_W  = 13;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  localparam int unsigned DATE_LAT = 9;
  localparam int unsigned TIME_LAT = 5;

  typedef struct packed {
    logic               valid;
    logic               err;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

  // days from 1 Jan to the first of month m, before the leap correction
  function automatic logic [YDAY_W-1:0] month_base(input logic [MONTH_W-1:0] m);
    logic [YDAY_W-1:0] b;
    unique case (m)
      4'd1:    b = 9'd0;
      4'd2:    b = 9'd31;
      4'd3:    b = 9'd61;
      4'd4:    b = 9'd92;
      4'd5:    b = 9'd122;
      4'd6:    b = 9'd153;
      4'd7:    b = 9'd183;
      4'd8:    b = 9'd214;
      4'd9:    b = 9'd245;
      4'd10:   b = 9'd275;
      4'd11:   b = 9'd306;
      4'd12:   b = 9'd336;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/jdc_date.sv
// ----------------------------------------------------------------------------
// jdc_date
// Nine-stage pipeline from offset civil day number to Gregorian year, month
// and day via 400/100/4/1-year cycle decomposition.
// ----------------------------------------------------------------------------
module jdc_date #(
  parameter int unsigned DAY_BITS = jdc_pkg::DAY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_err,
  input  logic [DAY_BITS-1:0] in_dep,
  output jdc_pkg::date_t      date_o
);

  localparam int unsigned QW   = DAY_BITS - 17;
  localparam int unsigned K400 = DAY_BITS + 18;
  localparam int unsigned PW   = 2 * DAY_BITS + 1;
  localparam longint unsigned M400_L =
    ((64'd1 << K400) + 64'(jdc_pkg::DAYS_400Y - 1)) / 64'(jdc_pkg::DAYS_400Y);
  localparam logic [DAY_BITS:0] M400 = M400_L[DAY_BITS:0];
  localparam int unsigned P1461_W = jdc_pkg::R100_W + jdc_pkg::M1461_W;
  localparam int unsigned P367_W  = jdc_pkg::MN_W + jdc_pkg::M367_W;

  logic [jdc_pkg::DATE_LAT-1:0] vld_r;
  logic [jdc_pkg::DATE_LAT-1:0] err_r;

  // stage 1
  logic [PW-1:0]       prod400;
  logic [QW-1:0]       q1_nxt, q1_r;
  logic [DAY_BITS-1:0] dep1_r;
  // stage 2
  logic [jdc_pkg::R400_W-1:0] r400_nxt, r400_r;
  logic [QW-1:0]              q2_r;
  // stage 3
  logic [jdc_pkg::C100_W-1:0] c100_nxt, c3_r;
  logic [jdc_pkg::R400_W-1:0] cbase;
  logic [jdc_pkg::R100_W-1:0] r100_nxt, r100_r;
  logic [QW-1:0]              q3_r;
  // stage 4
  logic [P1461_W-1:0]         prod1461;
  logic [jdc_pkg::Q4_W-1:0]   q4_nxt, q4_r;
  logic [jdc_pkg::R100_W-1:0] r100b_r;
  logic [jdc_pkg::C100_W-1:0] c4_r;
  logic [QW-1:0]              q4y_r;
  // stage 5
  logic [jdc_pkg::R4_W-1:0]   r4_nxt, r4_r;
  logic [jdc_pkg::Q4_W-1:0]   q4b_r;
  logic [jdc_pkg::C100_W-1:0] c5_r;
  logic [QW-1:0]              q5_r;
  // stage 6
  logic [jdc_pkg::YI_W-1:0]   yi;
  logic                       special;
  logic [jdc_pkg::YEAR_W-1:0] year_nxt, year6_r;
  logic [jdc_pkg::YDAY_W-1:0] yday_nxt, yday6_r;
  logic                       leap_nxt, leap6_r;
  // stage 7
  logic [jdc_pkg::YDAY_W-1:0] feb_end;
  logic [jdc_pkg::MN_W-1:0]   ladj;
  logic [jdc_pkg::MN_W-1:0]   n_nxt, n_r;
  logic [jdc_pkg::YEAR_W-1:0] year7_r;
  logic [jdc_pkg::YDAY_W-1:0] yday7_r;
  logic                       leap7_r;
  // stage 8
  logic [P367_W-1:0]           prod367;
  logic [jdc_pkg::MONTH_W-1:0] month_nxt, month8_r;
  logic [jdc_pkg::YEAR_W-1:0]  year8_r;
  logic [jdc_pkg::YDAY_W-1:0]  yday8_r;
  logic                        leap8_r;
  // stage 9
  logic [jdc_pkg::YDAY_W:0]    dsum;
  logic [jdc_pkg::YDAY_W:0]    madj;
  logic [jdc_pkg::DAY_W-1:0]   day_nxt, day9_r;
  logic [jdc_pkg::MONTH_W-1:0] month9_r;
  logic [jdc_pkg::YEAR_W-1:0]  year9_r;

  always_comb begin
    prod400 = PW'(in_dep) * PW'(M400);
    q1_nxt  = prod400[PW-1:K400];

    r400_nxt = jdc_pkg::R400_W'(dep1_r
               - DAY_BITS'(DAY_BITS'(q1_r) * DAY_BITS'(jdc_pkg::DAYS_400Y)));

    if (r400_r >= jdc_pkg::R400_W'(4 * jdc_pkg::DAYS_100Y)) begin
      c100_nxt = 3'd4;
      cbase    = jdc_pkg::R400_W'(4 * jdc_pkg::DAYS_100Y);
    end else if (r400_r >= jdc_pkg::R400_W'(3 * jdc_pkg::DAYS_100Y)) begin
      c100_nxt = 3'd3;
      cbase    = jdc_pkg::R400_W'(3 * jdc_pkg::DAYS_100Y);
    end else if (r400_r >= jdc_pkg::R400_W'(2 * jdc_pkg::DAYS_100Y)) begin
      c100_nxt = 3'd2;
      cbase    = jdc_pkg::R400_W'(2 * jdc_pkg::DAYS_100Y);
    end else if (r400_r >= jdc_pkg::R400_W'(jdc_pkg::DAYS_100Y)) begin
      c100_nxt = 3'd1;
      cbase    = jdc_pkg::R400_W'(jdc_pkg::DAYS_100Y);
    end else begin
      c100_nxt = 3'd0;
      cbase    = '0;
    end
    r100_nxt = jdc_pkg::R100_W'(r400_r - cbase);

    prod1461 = P1461_W'(r100_r) * P1461_W'(jdc_pkg::M1461);
    q4_nxt   = prod1461[jdc_pkg::K1461 +: jdc_pkg::Q4_W];

    r4_nxt = jdc_pkg::R4_W'(r100b_r
             - jdc_pkg::R100_W'(jdc_pkg::R100_W'(q4_r) * jdc_pkg::R100_W'(jdc_pkg::DAYS_4Y)));

    if (r4_r >= jdc_pkg::R4_W'(4 * jdc_pkg::DAYS_1Y)) begin
      yi = 3'd4;
    end else if (r4_r >= jdc_pkg::R4_W'(3 * jdc_pkg::DAYS_1Y)) begin
      yi = 3'd3;
    end else if (r4_r >= jdc_pkg::R4_W'(2 * jdc_pkg::DAYS_1Y)) begin
      yi = 3'd2;
    end else if (r4_r >= jdc_pkg::R4_W'(jdc_pkg::DAYS_1Y)) begin
      yi = 3'd1;
    end else begin
      yi = 3'd0;
    end
    // last day of a leap 4- or 400-year cycle
    special  = (c5_r == 3'd4) || (yi == 3'd4);
    year_nxt = jdc_pkg::YEAR_W'(q5_r) * jdc_pkg::YEAR_W'(jdc_pkg::YEAR_SPAN)
               - jdc_pkg::YEAR_W'(jdc_pkg::YEAR_SPAN)
               + jdc_pkg::YEAR_W'(c5_r) * jdc_pkg::YEAR_W'(jdc_pkg::CENT_SPAN)
               + jdc_pkg::YEAR_W'({q4b_r, 2'b00})
               + jdc_pkg::YEAR_W'(yi)
               + jdc_pkg::YEAR_W'(!special);
    yday_nxt = special ? jdc_pkg::YDAY_W'(jdc_pkg::DAYS_1Y)
                       : jdc_pkg::YDAY_W'(r4_r
                         - jdc_pkg::R4_W'(jdc_pkg::R4_W'(yi) * jdc_pkg::R4_W'(jdc_pkg::DAYS_1Y)));
    leap_nxt = special ||
               ((yi == 3'd3) && ((q4b_r != jdc_pkg::Q4_W'(24)) || (c5_r == 3'd3)));

    feb_end = jdc_pkg::YDAY_W'(jdc_pkg::DAYS_JAN_FEB) + jdc_pkg::YDAY_W'(leap6_r);
    if (yday6_r < feb_end) begin
      ladj = '0;
    end else begin
      ladj = leap6_r ? jdc_pkg::MN_W'(1) : jdc_pkg::MN_W'(2);
    end
    n_nxt = (jdc_pkg::MN_W'(yday6_r) + ladj) * jdc_pkg::MN_W'(jdc_pkg::MONTH_MUL)
            + jdc_pkg::MN_W'(jdc_pkg::MONTH_BIAS);

    prod367   = P367_W'(n_r) * P367_W'(jdc_pkg::M367);
    month_nxt = prod367[jdc_pkg::K367 +: jdc_pkg::MONTH_W];

    if (month8_r > jdc_pkg::MONTH_W'(2)) begin
      madj = leap8_r ? 10'd1 : 10'd2;
    end else begin
      madj = '0;
    end
    dsum    = 10'(yday8_r) + 10'd1 - 10'(jdc_pkg::month_base(month8_r)) + madj;
    day_nxt = jdc_pkg::DAY_W'(dsum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[jdc_pkg::DATE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    err_r    <= {err_r[jdc_pkg::DATE_LAT-2:0], in_err};
    dep1_r   <= in_dep;
    q1_r     <= q1_nxt;
    r400_r   <= r400_nxt;
    q2_r     <= q1_r;
    c3_r     <= c100_nxt;
    r100_r   <= r100_nxt;
    q3_r     <= q2_r;
    q4_r     <= q4_nxt;
    r100b_r  <= r100_r;
    c4_r     <= c3_r;
    q4y_r    <= q3_r;
    r4_r     <= r4_nxt;
    q4b_r    <= q4_r;
    c5_r     <= c4_r;
    q5_r     <= q4y_r;
    year6_r  <= year_nxt;
    yday6_r  <= yday_nxt;
    leap6_r  <= leap_nxt;
    n_r      <= n_nxt;
    year7_r  <= year6_r;
    yday7_r  <= yday6_r;
    leap7_r  <= leap6_r;
    month8_r <= month_nxt;
    year8_r  <= year7_r;
    yday8_r  <= yday7_r;
    leap8_r  <= leap7_r;
    day9_r   <= day_nxt;
    month9_r <= month8_r;
    year9_r  <= year8_r;
  end

  assign date_o = '{valid: vld_r[jdc_pkg::DATE_LAT-1],
                    err:   err_r[jdc_pkg::DATE_LAT-1],
                    year:  year9_r,
                    month: month9_r,
                    day:   day9_r};

endmodule

FILE: rtl/jdc_time.sv
// ----------------------------------------------------------------------------
// jdc_time
// Pipeline from civil day fraction to rounded hour, minute and second,
// padded to the latency of the date pipeline.
// ----------------------------------------------------------------------------
module jdc_time #(
  parameter int unsigned FRAC_BITS = jdc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] in_cf,
  output jdc_pkg::tod_t        tod_o
);

  localparam int unsigned TPW   = FRAC_BITS + jdc_pkg::SPD_W;
  localparam int unsigned P60AW = jdc_pkg::TOD_W + jdc_pkg::M60_W;
  localparam int unsigned P60BW = jdc_pkg::Q60_W + jdc_pkg::M60_W;
  localparam int unsigned PAD   = jdc_pkg::DATE_LAT - jdc_pkg::TIME_LAT;
  localparam logic [TPW-1:0] HALF = TPW'(1) << (FRAC_BITS - 1);

  logic [TPW-1:0]                 tp_nxt, tp_r;
  logic [jdc_pkg::TOD_W-1:0]      ij_nxt, ij_r, ij3_r;
  logic [P60AW-1:0]               p60a;
  logic [jdc_pkg::Q60_W-1:0]      q60_nxt, q60_r, q60b_r;
  logic [P60BW-1:0]               p60b;
  logic [jdc_pkg::HOUR_W-1:0]     hq_nxt, hq_r;
  logic [jdc_pkg::SEC_W-1:0]      sec_nxt, sec4_r;
  logic [jdc_pkg::MIN_W-1:0]      min_nxt;
  jdc_pkg::tod_t                  t5_r;
  jdc_pkg::tod_t                  pad_r [PAD];

  always_comb begin
    tp_nxt  = TPW'(in_cf) * TPW'(jdc_pkg::SECS_PER_DAY);
    ij_nxt  = jdc_pkg::TOD_W'((tp_r + HALF) >> FRAC_BITS);
    p60a    = P60AW'(ij_r) * P60AW'(jdc_pkg::M60);
    q60_nxt = p60a[jdc_pkg::K60 +: jdc_pkg::Q60_W];
    sec_nxt = jdc_pkg::SEC_W'(ij3_r
              - jdc_pkg::TOD_W'(jdc_pkg::TOD_W'(q60_r) * jdc_pkg::TOD_W'(jdc_pkg::SECS_PER_MIN)));
    p60b    = P60BW'(q60_r) * P60BW'(jdc_pkg::M60);
    hq_nxt  = p60b[jdc_pkg::K60 +: jdc_pkg::HOUR_W];
    min_nxt = jdc_pkg::MIN_W'(q60b_r
              - jdc_pkg::Q60_W'(jdc_pkg::Q60_W'(hq_r) * jdc_pkg::Q60_W'(jdc_pkg::SECS_PER_MIN)));
  end

  always_ff @(posedge clk) begin
    tp_r   <= tp_nxt;
    ij_r   <= ij_nxt;
    q60_r  <= q60_nxt;
    ij3_r  <= ij_r;
    hq_r   <= hq_nxt;
    sec4_r <= sec_nxt;
    q60b_r <= q60_r;
    t5_r   <= '{hour: hq_r, minute: min_nxt, second: sec4_r};
    pad_r[0] <= t5_r;
    for (int i = 1; i < PAD; i++) begin
      pad_r[i] <= pad_r[i-1];
    end
  end

  assign tod_o = pad_r[PAD-1];

endmodule

FILE: rtl/julian_date_to_calendar.sv
// ----------------------------------------------------------------------------
// julian_date_to_calendar
// Julian date (unsigned fixed point) to Gregorian date and rounded civil time.
//
//   channel  ports                          handshake
//   request  in_julian_fixed                start, busy
//   result   out_status .. out_second       out_strobe (one cycle)
//
// One request per cycle; busy is never raised and results cannot be held off,
// so nothing stalls.
// The accepting edge loads the decode stage, nine date stages follow (time
// of day runs alongside) and the output register, loaded after them, raises
// the result strobe.
// Synchronous active-low reset clears the valid pipeline only.
// ----------------------------------------------------------------------------
module julian_date_to_calendar #(
  parameter int unsigned DAY_BITS  = jdc_pkg::DAY_BITS_DEF,
  parameter int unsigned FRAC_BITS = jdc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [DAY_BITS+FRAC_BITS-1:0] in_julian_fixed,
  output logic                          out_strobe,
  output logic                          out_status,
  output logic [jdc_pkg::YEAR_W-1:0]    out_year,
  output logic [jdc_pkg::MONTH_W-1:0]   out_month,
  output logic [jdc_pkg::DAY_W-1:0]     out_day_of_month,
  output logic [jdc_pkg::HOUR_W-1:0]    out_hour,
  output logic [jdc_pkg::MIN_W-1:0]     out_minute,
  output logic [jdc_pkg::SEC_W-1:0]     out_second
);

  logic                 req;
  logic [DAY_BITS-1:0]  ipart;
  logic                 frac_hi;
  logic                 err_nxt;
  logic [DAY_BITS-1:0]  dep_nxt;
  logic [FRAC_BITS-1:0] cf_nxt;

  logic                 vld0_r;
  logic                 err0_r;
  logic [DAY_BITS-1:0]  dep0_r;
  logic [FRAC_BITS-1:0] cf0_r;

  jdc_pkg::date_t date;
  jdc_pkg::tod_t  tod;

  logic                        strobe_r;
  logic                        status_r;
  logic [jdc_pkg::YEAR_W-1:0]  year_r;
  logic [jdc_pkg::MONTH_W-1:0] month_r;
  logic [jdc_pkg::DAY_W-1:0]   day_r;
  logic [jdc_pkg::HOUR_W-1:0]  hour_r;
  logic [jdc_pkg::MIN_W-1:0]   minute_r;
  logic [jdc_pkg::SEC_W-1:0]   second_r;

  assign busy = 1'b0;
  assign req  = start & ~busy;

  // civil day starts at the half day; fraction rotated by a half day
  always_comb begin
    ipart   = in_julian_fixed[DAY_BITS+FRAC_BITS-1:FRAC_BITS];
    frac_hi = in_julian_fixed[FRAC_BITS-1];
    err_nxt = (ipart < DAY_BITS'(jdc_pkg::MIN_DAY)) ||
              ((ipart == DAY_BITS'(jdc_pkg::MIN_DAY)) && !frac_hi);
    dep_nxt = ipart - DAY_BITS'(jdc_pkg::DEP_OFS) - DAY_BITS'(!frac_hi);
    cf_nxt  = {~frac_hi, in_julian_fixed[FRAC_BITS-2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld0_r   <= req;
      strobe_r <= date.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      err0_r <= err_nxt;
      dep0_r <= dep_nxt;
      cf0_r  <= cf_nxt;
    end
    if (date.valid) begin
      status_r <= date.err;
      year_r   <= date.err ? '0 : date.year;
      month_r  <= date.err ? '0 : date.month;
      day_r    <= date.err ? '0 : date.day;
      hour_r   <= date.err ? '0 : tod.hour;
      minute_r <= date.err ? '0 : tod.minute;
      second_r <= date.err ? '0 : tod.second;
    end
  end

  jdc_date #(
    .DAY_BITS (DAY_BITS)
  ) u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld0_r),
    .in_err   (err0_r),
    .in_dep   (dep0_r),
    .date_o   (date)
  );

  jdc_time #(
    .FRAC_BITS (FRAC_BITS)
  ) u_time (
    .clk   (clk),
    .in_cf (cf0_r),
    .tod_o (tod)
  );

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = day_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;

endmodule
